// ----- hdl/msos_pkg.sv -----
// Shared constants, types and helpers for the mode switched open set.
package msos_pkg;

	localparam int CAPACITY = 1024;
	localparam int COORD_W  = 10;
	localparam int COST_W   = 16;
	localparam int PRI_W    = COST_W + 1;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KID_W    = CNT_W + 1;
	localparam int MODE_W   = 2;
	localparam int ST_W     = 2;

	localparam int IN_FIELDS_W  = 2 * COORD_W + 2 * COST_W;
	localparam int IN_TDATA_W   = (IN_FIELDS_W + 7) / 8 * 8;
	localparam int OUT_FIELDS_W = 2 * COORD_W + CNT_W;
	localparam int OUT_TDATA_W  = (OUT_FIELDS_W + 7) / 8 * 8;

	localparam logic [MODE_W-1:0] MODE_STACK = 2'd0;
	localparam logic [MODE_W-1:0] MODE_QUEUE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_HEAP  = 2'd2;

	typedef enum logic [ST_W-1:0] {
		ST_PUSHED = 2'd0,
		ST_POPPED = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef struct packed {
		logic [PRI_W-1:0]   pri;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x;
	} entry_t;

	// logical slot chosen for a memory access
	typedef enum logic [2:0] {
		SLOT_ROOT   = 3'd0,
		SLOT_TAIL   = 3'd1,
		SLOT_COUNT  = 3'd2,
		SLOT_POS    = 3'd3,
		SLOT_PARENT = 3'd4,
		SLOT_KID    = 3'd5,
		SLOT_KID2   = 3'd6
	} slot_sel_t;

	typedef enum logic [1:0] {
		WSRC_ENTRY  = 2'd0,
		WSRC_READ   = 2'd1,
		WSRC_CHOSEN = 2'd2
	} wsrc_t;

	typedef enum logic [2:0] {
		POS_HOLD   = 3'd0,
		POS_ZERO   = 3'd1,
		POS_COUNT  = 3'd2,
		POS_PARENT = 3'd3,
		POS_CHOSEN = 3'd4
	} pos_sel_t;

	typedef struct packed {
		logic      load_in;
		logic      rd_en;
		slot_sel_t rd_slot;
		logic      wr_en;
		slot_sel_t wr_slot;
		wsrc_t     wr_src;
		logic      cnt_inc;
		logic      cnt_dec;
		logic      head_adv;
		pos_sel_t  pos_sel;
		logic      kid_load;
		logic      entry_from_rd;
		logic      res_xy_load;
		logic      res_st_load;
		status_t   res_st;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		logic              is_pop;
		logic [MODE_W-1:0] mode;
		logic              full;
		logic              empty;
		logic              pos_zero;
		logic              up_stop;
		logic              kid_out;
		logic              dn_stop;
	} stat_t;

	// logical slot to physical address, ring rooted at the queue head
	function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] head,
			input logic [KID_W-1:0] logical);
		logic [KID_W:0] sum;
		sum = (KID_W + 1)'(head) + (KID_W + 1)'(logical);
		if (sum >= (KID_W + 1)'(CAPACITY)) begin
			sum = sum - (KID_W + 1)'(CAPACITY);
		end
		return sum[ADDR_W-1:0];
	endfunction

endpackage

// ----- hdl/msos_dp.sv -----
// Datapath: entry memory, count and head, sift registers and result register.
module msos_dp
	import msos_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output stat_t                  stat,
	input  logic                   cfg_valid,
	input  logic [MODE_W-1:0]      cfg_data,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                   s_axis_tuser,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic [ST_W-1:0]        m_axis_tuser
);

	entry_t mem [CAPACITY];

	logic [CNT_W-1:0]   count_q;
	logic [ADDR_W-1:0]  head_q;
	logic [MODE_W-1:0]  mode_q;
	logic [CNT_W-1:0]   pos_q;
	logic               pop_q;
	entry_t             entry_q;
	entry_t             rd_q;
	entry_t             kid_q;
	logic [COORD_W-1:0] res_x_q;
	logic [COORD_W-1:0] res_y_q;
	status_t            res_st_q;
	logic [COORD_W-1:0] out_x_q;
	logic [COORD_W-1:0] out_y_q;
	logic [CNT_W-1:0]   out_occ_q;
	status_t            out_st_q;

	logic [KID_W-1:0]  kid;
	logic [KID_W-1:0]  kid2;
	logic [CNT_W-1:0]  parent;
	logic              use2;
	entry_t            chosen;
	logic [CNT_W-1:0]  chosen_idx;
	logic [KID_W-1:0]  rd_log;
	logic [KID_W-1:0]  wr_log;
	entry_t            wr_data;
	logic [COORD_W-1:0] in_x;
	logic [COORD_W-1:0] in_y;
	logic [COST_W-1:0]  in_cost;
	logic [COST_W-1:0]  in_est;

	assign in_x    = s_axis_tdata[COORD_W-1:0];
	assign in_y    = s_axis_tdata[2*COORD_W-1:COORD_W];
	assign in_cost = s_axis_tdata[2*COORD_W+COST_W-1:2*COORD_W];
	assign in_est  = s_axis_tdata[IN_FIELDS_W-1:2*COORD_W+COST_W];

	assign kid        = {pos_q, 1'b1};
	assign kid2       = kid + KID_W'(1);
	assign parent     = (pos_q - CNT_W'(1)) >> 1;
	assign use2       = (kid2 < KID_W'(count_q)) && (rd_q.pri < kid_q.pri);
	assign chosen     = use2 ? rd_q : kid_q;
	assign chosen_idx = use2 ? kid2[CNT_W-1:0] : kid[CNT_W-1:0];

	function automatic logic [KID_W-1:0] slot_idx(input slot_sel_t sel);
		unique case (sel)
			SLOT_ROOT:   return '0;
			SLOT_TAIL:   return KID_W'(count_q) - KID_W'(1);
			SLOT_COUNT:  return KID_W'(count_q);
			SLOT_POS:    return KID_W'(pos_q);
			SLOT_PARENT: return KID_W'(parent);
			SLOT_KID:    return kid;
			SLOT_KID2:   return kid2;
			default:     return '0;
		endcase
	endfunction

	always_comb begin
		rd_log = slot_idx(cmd.rd_slot);
		wr_log = slot_idx(cmd.wr_slot);
	end

	always_comb begin
		unique case (cmd.wr_src)
			WSRC_ENTRY:  wr_data = entry_q;
			WSRC_READ:   wr_data = rd_q;
			WSRC_CHOSEN: wr_data = chosen;
			default:     wr_data = entry_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[phys(head_q, wr_log)] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[phys(head_q, rd_log)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			head_q  <= '0;
			mode_q  <= MODE_HEAP;
		end else begin
			if (cfg_valid) begin
				mode_q <= cfg_data;
			end
			if (cmd.cnt_inc) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.head_adv) begin
				head_q <= phys(head_q, KID_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			pop_q       <= s_axis_tuser;
			entry_q.x   <= in_x;
			entry_q.y   <= in_y;
			entry_q.pri <= PRI_W'(in_cost) + PRI_W'(in_est);
			res_x_q     <= '0;
			res_y_q     <= '0;
		end else if (cmd.entry_from_rd) begin
			entry_q <= rd_q;
		end
		if (cmd.res_xy_load) begin
			res_x_q <= rd_q.x;
			res_y_q <= rd_q.y;
		end
		if (cmd.res_st_load) begin
			res_st_q <= cmd.res_st;
		end
		if (cmd.kid_load) begin
			kid_q <= rd_q;
		end
		unique case (cmd.pos_sel)
			POS_HOLD:   pos_q <= pos_q;
			POS_ZERO:   pos_q <= '0;
			POS_COUNT:  pos_q <= count_q;
			POS_PARENT: pos_q <= parent;
			POS_CHOSEN: pos_q <= chosen_idx;
			default:    pos_q <= pos_q;
		endcase
		if (cmd.out_load) begin
			out_x_q   <= res_x_q;
			out_y_q   <= res_y_q;
			out_occ_q <= count_q;
			out_st_q  <= res_st_q;
		end
	end

	assign stat.is_pop   = pop_q;
	assign stat.mode     = mode_q;
	assign stat.full     = (count_q >= CNT_W'(CAPACITY));
	assign stat.empty    = (count_q == '0);
	assign stat.pos_zero = (pos_q == '0);
	assign stat.up_stop  = (rd_q.pri <= entry_q.pri);
	assign stat.kid_out  = (kid >= KID_W'(count_q));
	assign stat.dn_stop  = (entry_q.pri <= chosen.pri);

	assign m_axis_tdata = OUT_TDATA_W'({out_occ_q, out_y_q, out_x_q});
	assign m_axis_tuser = out_st_q;

endmodule

// ----- hdl/msos_ctrl.sv -----
// Controller: sequences push, pop and heap sifts over the datapath.
module msos_ctrl
	import msos_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_axis_tvalid,
	output logic  s_axis_tready,
	output logic  m_axis_tvalid,
	input  logic  m_axis_tready,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [10:0] {
		S_IDLE      = 11'b000_0000_0001,
		S_DISPATCH  = 11'b000_0000_0010,
		S_POP_WAIT  = 11'b000_0000_0100,
		S_HPOP_ROOT = 11'b000_0000_1000,
		S_HPOP_LAST = 11'b000_0001_0000,
		S_UP_CHK    = 11'b000_0010_0000,
		S_UP_CMP    = 11'b000_0100_0000,
		S_DN_CHK    = 11'b000_1000_0000,
		S_DN_RD2    = 11'b001_0000_0000,
		S_DN_CMP    = 11'b010_0000_0000,
		S_RESP      = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   m_valid_q, m_valid_d;
	logic   heap;

	assign heap = (stat.mode != MODE_STACK) && (stat.mode != MODE_QUEUE);

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				cmd.res_st_load = 1'b1;
				if (!stat.is_pop) begin
					if (stat.full) begin
						cmd.res_st = ST_FULL;
						state_d    = S_RESP;
					end else begin
						cmd.res_st  = ST_PUSHED;
						cmd.cnt_inc = 1'b1;
						if (heap) begin
							cmd.pos_sel = POS_COUNT;
							state_d     = S_UP_CHK;
						end else begin
							cmd.wr_en   = 1'b1;
							cmd.wr_slot = SLOT_COUNT;
							cmd.wr_src  = WSRC_ENTRY;
							state_d     = S_RESP;
						end
					end
				end else if (stat.empty) begin
					cmd.res_st = ST_EMPTY;
					state_d    = S_RESP;
				end else begin
					cmd.res_st = ST_POPPED;
					cmd.rd_en  = 1'b1;
					if (stat.mode == MODE_STACK) begin
						cmd.rd_slot = SLOT_TAIL;
						cmd.cnt_dec = 1'b1;
						state_d     = S_POP_WAIT;
					end else if (stat.mode == MODE_QUEUE) begin
						cmd.rd_slot  = SLOT_ROOT;
						cmd.cnt_dec  = 1'b1;
						cmd.head_adv = 1'b1;
						state_d      = S_POP_WAIT;
					end else begin
						cmd.rd_slot = SLOT_ROOT;
						state_d     = S_HPOP_ROOT;
					end
				end
			end
			S_POP_WAIT: begin
				cmd.res_xy_load = 1'b1;
				state_d         = S_RESP;
			end
			S_HPOP_ROOT: begin
				cmd.res_xy_load = 1'b1;
				cmd.rd_en       = 1'b1;
				cmd.rd_slot     = SLOT_TAIL;
				cmd.cnt_dec     = 1'b1;
				state_d         = S_HPOP_LAST;
			end
			S_HPOP_LAST: begin
				cmd.entry_from_rd = 1'b1;
				cmd.pos_sel       = POS_ZERO;
				state_d           = stat.empty ? S_RESP : S_DN_CHK;
			end
			S_UP_CHK: begin
				if (stat.pos_zero) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_slot = SLOT_POS;
					cmd.wr_src  = WSRC_ENTRY;
					state_d     = S_RESP;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_slot = SLOT_PARENT;
					state_d     = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_slot = SLOT_POS;
				if (stat.up_stop) begin
					cmd.wr_src = WSRC_ENTRY;
					state_d    = S_RESP;
				end else begin
					cmd.wr_src  = WSRC_READ;
					cmd.pos_sel = POS_PARENT;
					state_d     = S_UP_CHK;
				end
			end
			S_DN_CHK: begin
				if (stat.kid_out) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_slot = SLOT_POS;
					cmd.wr_src  = WSRC_ENTRY;
					state_d     = S_RESP;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_slot = SLOT_KID;
					state_d     = S_DN_RD2;
				end
			end
			S_DN_RD2: begin
				cmd.kid_load = 1'b1;
				cmd.rd_en    = 1'b1;
				cmd.rd_slot  = SLOT_KID2;
				state_d      = S_DN_CMP;
			end
			S_DN_CMP: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_slot = SLOT_POS;
				if (stat.dn_stop) begin
					cmd.wr_src = WSRC_ENTRY;
					state_d    = S_RESP;
				end else begin
					cmd.wr_src  = WSRC_CHOSEN;
					cmd.pos_sel = POS_CHOSEN;
					state_d     = S_DN_CHK;
				end
			end
			S_RESP: begin
				if (!m_valid_q || m_axis_tready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		if (cmd.out_load) begin
			m_valid_d = 1'b1;
		end else if (m_axis_tready) begin
			m_valid_d = 1'b0;
		end else begin
			m_valid_d = m_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			m_valid_q <= m_valid_d;
		end
	end

endmodule

// ----- hdl/mode_switched_open_set_core.sv -----
// Top level of the mode switched open set: controller plus datapath.
//
// Open-set store of up to 1024 (x, y, priority) entries, priority being
// path_cost + estimate. One word in gives one word out. cfg_data selects
// the pop order: 0 stack, 1 queue, 2 or 3 min-priority heap (reset 2);
// write it only while the block is idle. All entries sit in one
// single-port memory with a registered read, and that port sets the
// timing from input accept to result valid: a stack or queue push or pop
// makes one memory access; a heap push reads the parent and writes once
// per level climbed, and a heap pop reads the root and the last entry,
// then reads both children and writes once per level descended. One word
// is worked on at a time; the next input is accepted from the cycle after
// the result is loaded, even while that result waits in the output
// register, and a held result stalls only the following one.
module mode_switched_open_set_core
	import msos_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [MODE_W-1:0]      cfg_data,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// x_coord, y_coord, path_cost, estimate, zero pad
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// action
	input  logic                   s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// out_x, out_y, occupancy, zero pad
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// status
	output logic [ST_W-1:0]        m_axis_tuser
);

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	msos_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.stat          (stat),
		.cmd           (cmd)
	);

	msos_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the mode switched open set: stack, queue and heap disciplines.
`timescale 1ns / 1ps

module tb_top;
	import msos_pkg::*;

	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP  = 1'b1;
	localparam logic [MODE_W-1:0] MODE_HEAP_ALT = 2'd3;
	localparam int unsigned HEAP_FAN = 2;
	localparam int IDLE_PCT = 26;

	typedef struct {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		status_t            st;
		logic [CNT_W-1:0]   occ;
	} result_t;

	class open_set_shadow;
		logic [COORD_W-1:0] cell_x [CAPACITY];
		logic [COORD_W-1:0] cell_y [CAPACITY];
		logic [PRI_W-1:0]   cell_pri [CAPACITY];
		int unsigned        held;
		int unsigned        head;
		logic [MODE_W-1:0]  mode;
		result_t            due_results [$];
		int                 errors;
		int                 seen;

		function new();
			held = 0;
			head = 0;
			mode = MODE_HEAP;
			errors = 0;
			seen = 0;
		endfunction

		function int unsigned slot(int unsigned logical);
			return (head + logical) % CAPACITY;
		endfunction

		function void swap_slots(int unsigned a, int unsigned b);
			logic [COORD_W-1:0] tx;
			logic [COORD_W-1:0] ty;
			logic [PRI_W-1:0]   tp;
			tx = cell_x[slot(a)];
			ty = cell_y[slot(a)];
			tp = cell_pri[slot(a)];
			cell_x[slot(a)] = cell_x[slot(b)];
			cell_y[slot(a)] = cell_y[slot(b)];
			cell_pri[slot(a)] = cell_pri[slot(b)];
			cell_x[slot(b)] = tx;
			cell_y[slot(b)] = ty;
			cell_pri[slot(b)] = tp;
		endfunction

		function void sift_up(int unsigned pos);
			int unsigned up;
			while (pos > 0) begin
				up = (pos - 1) / HEAP_FAN;
				if (cell_pri[slot(up)] <= cell_pri[slot(pos)]) break;
				swap_slots(up, pos);
				pos = up;
			end
		endfunction

		function void sift_down(int unsigned limit);
			int unsigned pos;
			int unsigned k;
			pos = 0;
			k = 1;
			while (k < limit) begin
				if (k + 1 < limit && cell_pri[slot(k + 1)] < cell_pri[slot(k)]) k++;
				if (cell_pri[slot(pos)] <= cell_pri[slot(k)]) break;
				swap_slots(pos, k);
				pos = k;
				k = pos * HEAP_FAN + 1;
			end
		endfunction

		function void take_word(logic act, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
				logic [COST_W-1:0] cost, logic [COST_W-1:0] est);
			result_t     r;
			int unsigned p;
			r.x = '0;
			r.y = '0;
			if (act == ACT_PUSH) begin
				if (held >= CAPACITY) begin
					r.st = ST_FULL;
				end else begin
					p = slot(held);
					cell_x[p] = x;
					cell_y[p] = y;
					cell_pri[p] = PRI_W'(cost) + PRI_W'(est);
					held++;
					if (mode >= MODE_HEAP) sift_up(held - 1);
					r.st = ST_PUSHED;
				end
			end else if (held == 0) begin
				r.st = ST_EMPTY;
			end else if (mode == MODE_STACK) begin
				p = slot(held - 1);
				r.x = cell_x[p];
				r.y = cell_y[p];
				held--;
				r.st = ST_POPPED;
			end else if (mode == MODE_QUEUE) begin
				p = slot(0);
				r.x = cell_x[p];
				r.y = cell_y[p];
				head = slot(1);
				held--;
				r.st = ST_POPPED;
			end else begin
				p = slot(0);
				r.x = cell_x[p];
				r.y = cell_y[p];
				held--;
				if (held > 0) begin
					cell_x[p] = cell_x[slot(held)];
					cell_y[p] = cell_y[slot(held)];
					cell_pri[p] = cell_pri[slot(held)];
					sift_down(held);
				end
				r.st = ST_POPPED;
			end
			r.occ = CNT_W'(held);
			due_results.push_back(r);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task match_word(logic [OUT_TDATA_W-1:0] d, logic [ST_W-1:0] st);
			result_t r;
			seen++;
			if (due_results.size() == 0) begin
				report($sformatf("unexpected word tdata=%h tuser=%0d", d, st));
			end else begin
				r = due_results.pop_front();
				if (d[COORD_W-1:0] !== r.x)
					report($sformatf("out_x %0d, want %0d", d[COORD_W-1:0], r.x));
				if (d[2*COORD_W-1:COORD_W] !== r.y)
					report($sformatf("out_y %0d, want %0d", d[2*COORD_W-1:COORD_W], r.y));
				if (st !== r.st)
					report($sformatf("status %0d, want %0d", st, r.st));
				if (d[2*COORD_W+CNT_W-1:2*COORD_W] !== r.occ)
					report($sformatf("occupancy %0d, want %0d",
						d[2*COORD_W+CNT_W-1:2*COORD_W], r.occ));
			end
		endtask

		function int pending();
			return due_results.size();
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [MODE_W-1:0]      cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   s_tuser = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [ST_W-1:0]        m_axis_tuser;

	open_set_shadow sb;

	mode_switched_open_set_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// no idling in a stretch in the middle of the run
	function automatic bit idle_roll();
		if (sb.seen >= 700 && sb.seen < 950) return 1'b0;
		return $urandom_range(99) < IDLE_PCT;
	endfunction

	task automatic send_word(input logic act, input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y, input logic [COST_W-1:0] cost,
			input logic [COST_W-1:0] est);
		while (idle_roll()) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= IN_TDATA_W'({est, cost, y, x});
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.take_word(act, x, y, cost, est);
	endtask

	function automatic logic [COST_W-1:0] rand_cost();
		if ($urandom_range(99) < 25) return COST_W'($urandom_range(0, 7));
		return COST_W'($urandom);
	endfunction

	task automatic send_random(input int pop_pct);
		logic act;
		act = ($urandom_range(99) < pop_pct) ? ACT_POP : ACT_PUSH;
		send_word(act, COORD_W'($urandom), COORD_W'($urandom), rand_cost(), rand_cost());
	endtask

	task automatic run_phase(input int n_words, input int pop_pct);
		repeat (n_words) send_random(pop_pct);
	endtask

	task automatic write_mode(input logic [MODE_W-1:0] m);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		sb.mode = m;
	endtask

	initial begin : drain_results
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_tready) sb.match_word(m_axis_tdata, m_axis_tuser);
			if (!hold_done && sb.seen >= 300) begin
				hold_done = 1'b1;
				hold_left = 600;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !idle_roll();
			end
		end
	end

	initial begin : stimulus
		int drops;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// heap mode out of reset: empty pop, extremes, tie on priority
		send_word(ACT_POP, '1, '1, '1, '1);
		send_word(ACT_PUSH, '0, '0, '0, '0);
		send_word(ACT_PUSH, '1, '1, '1, '1);
		send_word(ACT_PUSH, 10'd5, 10'd7, 16'd100, 16'd50);
		send_word(ACT_PUSH, 10'd9, 10'd3, 16'd150, 16'd0);
		send_word(ACT_PUSH, 10'd1, 10'd2, '1, '0);
		send_word(ACT_PUSH, 10'd3, 10'd4, '0, '1);
		repeat (7) send_word(ACT_POP, '0, '0, '0, '0);

		write_mode(MODE_STACK);
		send_word(ACT_PUSH, 10'd11, 10'd12, 16'd1, 16'd1);
		send_word(ACT_PUSH, 10'd13, 10'd14, 16'd2, 16'd2);
		repeat (3) send_word(ACT_POP, '0, '0, '0, '0);

		write_mode(MODE_QUEUE);
		send_word(ACT_PUSH, 10'd21, 10'd22, 16'd3, 16'd3);
		send_word(ACT_PUSH, 10'd23, 10'd24, 16'd4, 16'd4);
		send_word(ACT_POP, '0, '0, '0, '0);
		send_word(ACT_POP, '0, '0, '0, '0);

		write_mode(MODE_HEAP);
		run_phase(120, 40);
		write_mode(MODE_QUEUE);
		run_phase(80, 50);
		write_mode(MODE_STACK);
		run_phase(60, 50);

		// queue mode with a moved head, filled past capacity
		write_mode(MODE_QUEUE);
		drops = 0;
		while (drops < 6) begin
			if (sb.held == CAPACITY) drops++;
			send_random(4);
		end

		// heap discipline over a store laid out as a ring
		write_mode(MODE_HEAP_ALT);
		run_phase(80, 65);
		write_mode(MODE_STACK);
		run_phase(40, 80);

		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
